// File: hw/rtl/plb_pkg.sv
// plb_pkg: field widths, register indexes and shared types for the palette blitter.
// Used by every module of palette_blit_with_transparency; depends on nothing.
`default_nettype none
package plb_pkg;

   localparam int ORIGIN_W = 12;
   localparam int SIZE_FIELD_W = 13;
   localparam int CODE_W = 8;
   localparam int COLOR_W = 32;
   localparam int ADDR_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X         = 3'd0,
      CSR_ORIGIN_Y         = 3'd1,
      CSR_SOURCE_WIDTH     = 3'd2,
      CSR_SOURCE_HEIGHT    = 3'd3,
      CSR_TARGET_WIDTH     = 3'd4,
      CSR_TARGET_HEIGHT    = 3'd5,
      CSR_TRANSPARENT_MODE = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_PALETTE_WRITE = 1'b1
   } operation_type;

   typedef struct packed {
      logic [ORIGIN_W-1:0]     origin_x;
      logic [ORIGIN_W-1:0]     origin_y;
      logic [SIZE_FIELD_W-1:0] source_width;
      logic [SIZE_FIELD_W-1:0] source_height;
      logic [SIZE_FIELD_W-1:0] target_width;
      logic [SIZE_FIELD_W-1:0] target_height;
      logic                    transparent_mode;
   } cfg_type;

   typedef struct packed {
      logic              visible;
      logic              frame_last;
      logic [ADDR_W-1:0] product;
      logic [ADDR_W-1:0] offset;
   } pos_type;

endpackage
`default_nettype wire

// File: hw/rtl/palette_blit_with_transparency.sv
// palette_blit_with_transparency: expands indexed source pixels into 32-bit destination writes.
// Usage:
//   req_* carries one beat per source pixel code or palette load (req_operation).
//   Pixel codes arrive row by row over the source rectangle set in the csr_* registers.
//   Every accepted beat gives exactly one rsp_* beat, in order: destination address,
//   palette colour, write enable (clipped to the target, and in transparent mode only
//   for nonzero colour) and frame_last on the last pixel of the rectangle.
//   Palette loads answer with an all-zero beat and do not move the position.
// Timing:
//   From req accept to rsp_valid a beat passes a first stage, which holds the
//   registered palette read and the address terms, then the output register,
//   which adds them. Throughput is one beat per cycle while rsp_stall is low;
//   the palette memory port and the position counters each take one beat
//   per cycle. When rsp_stall is held the first stage still takes one more
//   beat, then req_stall rises until the output register drains.
// Reset: synchronous, active high; clears both stages, the position counters and
//   the registers to their defaults (sizes 1, origin 0, transparency off). The
//   palette holds no defined value until loaded. Write registers only while idle.
// Depends on plb_pkg, plb_palette and plb_position.
`default_nettype none
module palette_blit_with_transparency #(
   parameter int MAX_DIMENSION = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_operation,
   input  wire logic [plb_pkg::CODE_W-1:0]         req_entry_index,
   input  wire logic [plb_pkg::COLOR_W-1:0]        req_entry_color,
   input  wire logic [plb_pkg::CODE_W-1:0]         req_pixel_code,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_write_enable,
   output logic      [plb_pkg::ADDR_W-1:0]         rsp_pixel_address,
   output logic      [plb_pkg::COLOR_W-1:0]        rsp_pixel_color,
   output logic                                    rsp_frame_last,
   input  wire logic                               csr_write_enable,
   input  wire logic [plb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [plb_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int PAL_W = $clog2(PALETTE_ENTRIES);

   plb_pkg::cfg_type cfg_ff, cfg_in;

   logic accept, pixel_beat, palette_wr, advance;
   logic a_valid_ff, a_valid_in;
   logic a_pix_ff, a_code_ok_ff;
   logic [plb_pkg::COLOR_W-1:0] rd_color;
   plb_pkg::pos_type pos;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_we_ff, rsp_we_in;
   logic [plb_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [plb_pkg::COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [plb_pkg::COLOR_W-1:0] color;

   // registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (plb_pkg::csr_index_type'(csr_index))
            plb_pkg::CSR_ORIGIN_X:
               cfg_in.origin_x = csr_write_data[plb_pkg::ORIGIN_W-1:0];
            plb_pkg::CSR_ORIGIN_Y:
               cfg_in.origin_y = csr_write_data[plb_pkg::ORIGIN_W-1:0];
            plb_pkg::CSR_SOURCE_WIDTH:     cfg_in.source_width = csr_write_data;
            plb_pkg::CSR_SOURCE_HEIGHT:    cfg_in.source_height = csr_write_data;
            plb_pkg::CSR_TARGET_WIDTH:     cfg_in.target_width = csr_write_data;
            plb_pkg::CSR_TARGET_HEIGHT:    cfg_in.target_height = csr_write_data;
            plb_pkg::CSR_TRANSPARENT_MODE: cfg_in.transparent_mode = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: '0, origin_y: '0,
                     source_width: plb_pkg::SIZE_FIELD_W'(1),
                     source_height: plb_pkg::SIZE_FIELD_W'(1),
                     target_width: plb_pkg::SIZE_FIELD_W'(1),
                     target_height: plb_pkg::SIZE_FIELD_W'(1),
                     transparent_mode: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = a_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign pixel_beat = accept && (req_operation == plb_pkg::OP_PIXEL);
   assign palette_wr = accept && (req_operation == plb_pkg::OP_PALETTE_WRITE)
                       && (32'(req_entry_index) < PALETTE_ENTRIES);

   plb_palette #(
      .ENTRIES(PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (palette_wr),
      .wr_index(req_entry_index[PAL_W-1:0]),
      .wr_data (req_entry_color),
      .rd_en   (pixel_beat),
      .rd_index(req_pixel_code[PAL_W-1:0]),
      .rd_data (rd_color)
   );

   plb_position #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_position (
      .clock(clock),
      .reset(reset),
      .cfg  (cfg_ff),
      .load (pixel_beat),
      .pos  (pos)
   );

   // first stage
   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff <= (req_operation == plb_pkg::OP_PIXEL);
         a_code_ok_ff <= (32'(req_pixel_code) < PALETTE_ENTRIES);
      end
   end

   // output register
   always_comb begin
      color = (a_pix_ff && a_code_ok_ff) ? rd_color : '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_we_in = rsp_we_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = a_valid_ff;
         rsp_color_in = color;
         rsp_we_in = a_pix_ff && pos.visible && (!cfg_ff.transparent_mode || color != '0);
         rsp_addr_in = a_pix_ff ? (pos.product + pos.offset) : '0;
         rsp_last_in = a_pix_ff && pos.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_we_ff <= rsp_we_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef ASSERT_OFF
   a_load_beat_zero: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_pix_ff && advance |=>
         rsp_valid_ff && !rsp_write_enable && rsp_pixel_address == '0
         && rsp_pixel_color == '0 && !rsp_frame_last)
      else $error("palette load beat gave a nonzero result");
   a_transparent_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_write_enable && cfg_ff.transparent_mode |-> rsp_pixel_color != '0)
      else $error("zero colour written in transparent mode");
   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !advance |=> a_valid_ff && $stable(a_pix_ff))
      else $error("first stage lost a beat while output stalled");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/plb_palette.sv
// plb_palette: palette store, one write port and one registered read port.
// Depends on plb_pkg for the colour width.
`default_nettype none
module plb_palette #(
   parameter int ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0]          wr_index,
   input  wire logic [plb_pkg::COLOR_W-1:0]         wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0]          rd_index,
   output logic      [plb_pkg::COLOR_W-1:0]         rd_data
);

   logic [plb_pkg::COLOR_W-1:0] store_ff [ENTRIES];
   logic [plb_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/plb_position.sv
// plb_position: source position counters, clipping and address terms for each pixel beat.
// Depends on plb_pkg for cfg_type and pos_type.
`default_nettype none
module plb_position #(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire plb_pkg::cfg_type cfg,
   input  wire logic             load,
   output plb_pkg::pos_type      pos
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);
   localparam int SIZE_W = $clog2(MAX_DIMENSION + 1);
   localparam int POS_W = ((SIZE_W > plb_pkg::ORIGIN_W) ? SIZE_W : plb_pkg::ORIGIN_W) + 1;
   localparam int AW = plb_pkg::ADDR_W;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [plb_pkg::SIZE_FIELD_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > MAX_DIMENSION) begin
         r = SIZE_W'(MAX_DIMENSION);
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [AW-1:0]    row_base_ff, row_base_in;
   plb_pkg::pos_type pos_ff, pos_in;

   logic [SIZE_W-1:0] sw, sh, tw, th;
   logic [POS_W-1:0]  dx, dy;
   logic              row_end, frame_end;

   always_comb begin
      sw = eff_size(cfg.source_width);
      sh = eff_size(cfg.source_height);
      tw = eff_size(cfg.target_width);
      th = eff_size(cfg.target_height);
      dx = POS_W'(cfg.origin_x) + POS_W'(col_ff);
      dy = POS_W'(cfg.origin_y) + POS_W'(row_ff);
      row_end = ((SIZE_W + 1)'(col_ff) + (SIZE_W + 1)'(1)) >= (SIZE_W + 1)'(sw);
      frame_end = row_end && (((SIZE_W + 1)'(row_ff) + (SIZE_W + 1)'(1)) >= (SIZE_W + 1)'(sh));

      pos_in.visible = (dx < POS_W'(tw)) && (dy < POS_W'(th));
      pos_in.frame_last = frame_end;
      pos_in.product = AW'(AW'(cfg.origin_y) * AW'(tw));
      pos_in.offset = AW'(cfg.origin_x) + row_base_ff + AW'(col_ff);

      col_in = col_ff;
      row_in = row_ff;
      row_base_in = row_base_ff;
      if (load) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            row_base_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
            row_base_in = row_base_ff + AW'(tw);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         row_base_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         row_base_ff <= row_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

`ifndef ASSERT_OFF
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      load && frame_end |=> col_ff == '0 && row_ff == '0 && row_base_ff == '0)
      else $error("position counters not cleared after last pixel of frame");
   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      load && !row_end |=> $stable(row_ff) && $stable(row_base_ff))
      else $error("row moved inside a source row");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(col_ff) && $stable(row_ff))
      else $error("position moved without a pixel beat");
`endif

endmodule
`default_nettype wire
